/* hw/rtl/ccbe_pkg.sv */
// Package for the configurable CRC byte engine.
// Holds register indexes, reset values, shared item types and bit-reversal functions.
// No dependencies.
`timescale 1ns / 1ps

package ccbe_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CRC_W-1:0] ZIP_POLY_NORMAL = 32'h04C11DB7;
  localparam logic [CRC_W-1:0] ALL_ONES_32     = 32'hFFFFFFFF;
  localparam logic [CRC_W-1:0] ALL_ONES_16     = 32'h0000FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_SELECT = 3'd0,
    CFG_POLYNOMIAL   = 3'd1,
    CFG_INIT_VALUE   = 3'd2,
    CFG_REFLECT_MODE = 3'd3,
    CFG_FINAL_XOR    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic             width_select;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic             reflect_mode;
    logic [CRC_W-1:0] final_xor;
  } cfg_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc_value;
    logic             message_done;
  } out_item_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rev16(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W; i++) begin
      r[i] = v[HALF_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/ccbe_step.sv */
// Byte update of the CRC register: eight shift-and-XOR steps plus result formatting.
// Depends on ccbe_pkg for the configuration and item types and the reversal functions.
`timescale 1ns / 1ps

module ccbe_step (
  input  ccbe_pkg::cfg_t              cfg,
  input  logic [ccbe_pkg::CRC_W-1:0]  crc_cur,
  input  logic [ccbe_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output logic [ccbe_pkg::CRC_W-1:0]  crc_upd,
  output ccbe_pkg::out_item_t         item
);
  import ccbe_pkg::*;

  logic [CRC_W-1:0]  mask;
  logic [CRC_W-1:0]  poly;
  logic [CRC_W-1:0]  r;
  logic [CRC_W-1:0]  shown;
  logic [BYTE_W-1:0] b;
  logic              top;

  always_comb begin
    mask = cfg.width_select ? ALL_ONES_32 : ALL_ONES_16;
    poly = cfg.polynomial & mask;
    b    = cfg.reflect_mode ? rev8(data_byte) : data_byte;
    r    = crc_cur & mask;
    if (cfg.width_select) begin
      r = r ^ {b, 24'h000000};
    end else begin
      r = r ^ {16'h0000, b, 8'h00};
    end
    for (int i = 0; i < BYTE_W; i++) begin
      top = cfg.width_select ? r[CRC_W-1] : r[HALF_W-1];
      r   = ((r << 1) ^ (top ? poly : '0)) & mask;
    end
    crc_upd = r;
    if (!cfg.reflect_mode) begin
      shown = r;
    end else if (cfg.width_select) begin
      shown = rev32(r);
    end else begin
      shown = {16'h0000, rev16(r[HALF_W-1:0])};
    end
    item.crc_value    = (shown ^ cfg.final_xor) & mask;
    item.message_done = last_byte;
  end

endmodule

/* hw/rtl/ccbe_out_buf.sv */
// Two-entry output stage: an output register backed by a skid register.
// Depends on ccbe_pkg for the result item type.
`timescale 1ns / 1ps

module ccbe_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ccbe_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output ccbe_pkg::out_item_t out_item
);
  import ccbe_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  out_item_t main_r;
  out_item_t skid_r;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_item  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r       <= push_item;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_item;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

endmodule

/* hw/rtl/configurable_crc_byte_engine.sv */
// Top level of the configurable CRC byte engine: configuration registers and CRC register.
// Depends on ccbe_pkg, ccbe_step and ccbe_out_buf.
`timescale 1ns / 1ps

// The engine folds one message byte per clock, unless stalled, into a 16- or 32-bit CRC with
// a programmable polynomial, initial value, reflection and final XOR; reset selects the zip
// CRC-32 setup. Each accepted byte gives a registered result item with the running CRC and a
// copy of the last flag, and a new byte can be taken every cycle unless stalled: the eight
// bit steps of the byte update sit between the CRC register and the output register. The
// two-entry output stage's skid register takes one item while out_stall is high. After a
// last byte the CRC register reloads init_value, and writing init_value also restarts the
// message. Write configuration only when no item is in flight; cfg_ready is always high.

module configurable_crc_byte_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ccbe_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccbe_pkg::CRC_W-1:0]    out_crc_value,
  output logic                          out_message_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccbe_pkg::CRC_W-1:0]    cfg_data
);
  import ccbe_pkg::*;

  cfg_t             cfg_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] crc_upd;
  out_item_t        step_item;
  out_item_t        out_item;
  logic             buf_full;
  logic             in_accept;
  logic             cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  ccbe_step u_step (
    .cfg       (cfg_r),
    .crc_cur   (crc_r),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .crc_upd   (crc_upd),
    .item      (step_item)
  );

  ccbe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (step_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_crc_value    = out_item.crc_value;
  assign out_message_done = out_item.message_done;

  always_comb begin
    crc_nxt = crc_r;
    if (in_accept) begin
      crc_nxt = in_last_byte ? cfg_r.init_value : crc_upd;
    end
    if (cfg_write && cfg_index == CFG_INIT_VALUE) begin
      crc_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_select <= 1'b1;
      cfg_r.polynomial   <= ZIP_POLY_NORMAL;
      cfg_r.init_value   <= ALL_ONES_32;
      cfg_r.reflect_mode <= 1'b1;
      cfg_r.final_xor    <= ALL_ONES_32;
      crc_r              <= ALL_ONES_32;
    end else begin
      crc_r <= crc_nxt;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WIDTH_SELECT: cfg_r.width_select <= cfg_data[0];
          CFG_POLYNOMIAL:   cfg_r.polynomial   <= cfg_data;
          CFG_INIT_VALUE:   cfg_r.init_value   <= cfg_data;
          CFG_REFLECT_MODE: cfg_r.reflect_mode <= cfg_data[0];
          CFG_FINAL_XOR:    cfg_r.final_xor    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  // The skid entry is only ever occupied behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry holds an item while the output register is empty");

  // A closed message always leaves the CRC register at the initial value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_byte) |=> (crc_r == cfg_r.init_value))
    else $error("CRC register not reloaded after the last byte");

  // At width 16 a computed result never carries bits in its upper half.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !cfg_r.width_select) |-> (step_item.crc_value[CRC_W-1:HALF_W] == '0))
    else $error("upper half of a 16-bit result is not zero");

  // A write to init_value restarts the message with the written value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_write && cfg_index == CFG_INIT_VALUE) |=> (crc_r == $past(cfg_data)))
    else $error("init write did not load the CRC register");
`endif

endmodule
